// ----- rtl/aabb_collision_resolve_defines.svh -----
// Assertion macros shared by the box collision block.
`ifndef AABB_COLLISION_RESOLVE_DEFINES_SVH
`define AABB_COLLISION_RESOLVE_DEFINES_SVH
`ifndef SYNTH
// Checked after reset has been released.
`define ACR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define ACR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ACR_ASSERT(lbl, prop, msg)
`define ACR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/acr_pkg.sv -----
// Shared constants and types of the box collision block.
`default_nettype none
package acr_pkg;

  // Default value width (Q16.16 words).
  localparam int WORD_BITS_DEF = 32;

  // Damping register: unsigned Q0.16, reset to about 0.7.
  localparam int DAMP_BITS = 16;
  localparam logic [DAMP_BITS-1:0] DAMP_RESET = 16'd45875;

  // Number of spatial axes.
  localparam int AXES = 3;

  // Item modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  // Resolution axis codes.
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // Result flags, hit in the lowest bit, then the axis.
  typedef struct packed {
    axis_e axis;
    logic  hit;
  } acr_flags_t;

endpackage
`default_nettype wire

// ----- rtl/aabb_collision_resolve.sv -----
// Two register stages, input stage and result register; a test item's result is offered
// from the result register. Throughput: one item per cycle while the result stream is not
// stalled, set by the input stage and the result register.
// A load item updates the obstacle as it leaves the input stage and gives no result.
// Reset empties both stages, sets the obstacle to a zero-size box at the origin
// and the damping register to 45875 (about 0.7).
`default_nettype none
`include "aabb_collision_resolve_defines.svh"
module aabb_collision_resolve #(
  parameter int WORD_BITS = acr_pkg::WORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Damping register write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [acr_pkg::DAMP_BITS-1:0] cfg_data_i,
  // Input stream.
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // From bit 0: pos_x, pos_y, pos_z, half_x, half_y, half_z, vel_x, vel_y, vel_z.
  input  logic [((9*WORD_BITS-3)+7)/8*8-1:0]       s_axis_tdata_i,
  // Bit 0: mode.
  input  logic [0:0]                               s_axis_tuser_i,
  // Result stream.
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  // From bit 0: new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z.
  output logic [(6*WORD_BITS+7)/8*8-1:0]           m_axis_tdata_o,
  // From bit 0: hit, axis (2 bits).
  output logic [2:0]                               m_axis_tuser_o
);
  import acr_pkg::*;

  localparam int W        = WORD_BITS;
  localparam int OUT_BITS = (6*WORD_BITS+7)/8*8;
  localparam int HALF_OFS = 3*W;
  localparam int VEL_OFS  = 6*W - 3;

  logic [DAMP_BITS-1:0] damping_q;

  // Front-end results of the incoming item.
  logic signed [W-1:0] in_c    [AXES];
  logic        [W-2:0] in_h    [AXES];
  logic signed [W-1:0] in_v    [AXES];
  logic signed [W:0]   in_mn   [AXES];
  logic signed [W:0]   in_mx   [AXES];
  logic signed [W:0]   in_nv   [AXES];

  // Input stage.
  logic                s1_valid_q;
  logic                s1_mode_q;
  logic signed [W-1:0] s1_c_q  [AXES];
  logic signed [W-1:0] s1_v_q  [AXES];
  logic signed [W:0]   s1_mn_q [AXES];
  logic signed [W:0]   s1_mx_q [AXES];
  logic signed [W:0]   s1_nv_q [AXES];

  // Obstacle, held as its limits.
  logic signed [W:0]   obs_mn_q [AXES];
  logic signed [W:0]   obs_mx_q [AXES];

  // Displacement and response of the staged item.
  logic signed [W+1:0] disp     [AXES];
  logic        [W+1:0] mag      [AXES];
  logic [AXES-1:0]     overlap;
  acr_flags_t          flags;
  logic signed [W-1:0] new_pos  [AXES];
  logic signed [W-1:0] new_vel  [AXES];
  logic [6*W-1:0]      out_pay_d;

  // Result register.
  logic                out_valid_q;
  acr_flags_t          out_flags_q;
  logic [6*W-1:0]      out_pay_q;

  logic out_load;
  logic s1_adv;
  logic s1_load_item;

  // Configuration: always ready; the user must write it only while the block is idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q <= DAMP_RESET;
    end else if (cfg_valid_i) begin
      damping_q <= cfg_data_i;
    end
  end

  // Unpack the input fields and compute limits and damped velocity per axis.
  for (genvar i = 0; i < AXES; i++) begin : g_front
    assign in_c[i] = s_axis_tdata_i[i*W +: W];
    assign in_h[i] = s_axis_tdata_i[HALF_OFS + i*(W-1) +: W-1];
    assign in_v[i] = s_axis_tdata_i[VEL_OFS + i*W +: W];

    acr_prep #(.WORD_BITS(WORD_BITS)) u_prep (
      .center_i  (in_c[i]),
      .half_i    (in_h[i]),
      .vel_i     (in_v[i]),
      .damping_i (damping_q),
      .min_o     (in_mn[i]),
      .max_o     (in_mx[i]),
      .vel_damp_o(in_nv[i])
    );
  end

  // Flow control: a load item leaves the input stage without a result slot.
  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign s1_load_item    = s1_valid_q && (s1_mode_q == MODE_LOAD);
  assign s1_adv          = !s1_valid_q || (s1_mode_q == MODE_LOAD) || out_load;
  assign s_axis_tready_o = s1_adv;

  // Control state of both stages and the obstacle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        obs_mn_q[i] <= '0;
        obs_mx_q[i] <= '0;
      end
    end else begin
      if (s1_adv) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q && (s1_mode_q == MODE_TEST);
      end
      if (s1_load_item) begin
        for (int i = 0; i < AXES; i++) begin
          obs_mn_q[i] <= s1_mn_q[i];
          obs_mx_q[i] <= s1_mx_q[i];
        end
      end
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (s1_adv && s_axis_tvalid_i) begin
      s1_mode_q <= s_axis_tuser_i[0];
      for (int i = 0; i < AXES; i++) begin
        s1_c_q[i]  <= in_c[i];
        s1_v_q[i]  <= in_v[i];
        s1_mn_q[i] <= in_mn[i];
        s1_mx_q[i] <= in_mx[i];
        s1_nv_q[i] <= in_nv[i];
      end
    end
  end

  // Overlap and displacement of the staged box against the obstacle.
  for (genvar i = 0; i < AXES; i++) begin : g_disp
    acr_disp #(.WORD_BITS(WORD_BITS)) u_disp (
      .min_i    (s1_mn_q[i]),
      .max_i    (s1_mx_q[i]),
      .obs_min_i(obs_mn_q[i]),
      .obs_max_i(obs_mx_q[i]),
      .overlap_o(overlap[i]),
      .disp_o   (disp[i]),
      .mag_o    (mag[i])
    );
  end

  acr_resolve #(.WORD_BITS(WORD_BITS)) u_resolve (
    .center_i  (s1_c_q),
    .vel_i     (s1_v_q),
    .vel_damp_i(s1_nv_q),
    .disp_i    (disp),
    .mag_i     (mag),
    .overlap_i (overlap),
    .flags_o   (flags),
    .pos_o     (new_pos),
    .vel_o     (new_vel)
  );

  // Pack positions first, then velocities.
  for (genvar i = 0; i < AXES; i++) begin : g_pack
    assign out_pay_d[i*W +: W]        = new_pos[i];
    assign out_pay_d[(AXES+i)*W +: W] = new_vel[i];
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q && (s1_mode_q == MODE_TEST)) begin
      out_flags_q <= flags;
      out_pay_q   <= out_pay_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_BITS'(out_pay_q);
  assign m_axis_tuser_o  = out_flags_q;

  // A load item never fills the result register.
  `ACR_ASSERT(a_load_no_result, s1_load_item |=> (out_valid_q == $past(out_valid_q && !m_axis_tready_i)), "load item produced a result")
  // A staged test item reaches the result register when it has room.
  `ACR_ASSERT(a_test_moves_on, (s1_valid_q && (s1_mode_q == MODE_TEST) && out_load) |=> out_valid_q, "test item lost")
  // The obstacle's x minimum and z maximum change only after a load item.
  `ACR_ASSERT(a_obstacle_hold, !s1_load_item |=> ($stable(obs_mn_q[0]) && $stable(obs_mx_q[2])), "obstacle changed without load")
  // An edge taken under reset leaves no result offered.
  `ACR_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o, "result valid after reset")

endmodule
`default_nettype wire

// ----- rtl/acr_prep.sv -----
// Per-axis front end: box limits and damped velocity of one incoming item.
`default_nettype none
module acr_prep #(
  parameter int WORD_BITS = acr_pkg::WORD_BITS_DEF
) (
  input  logic signed [WORD_BITS-1:0]          center_i,
  input  logic        [WORD_BITS-2:0]          half_i,
  input  logic signed [WORD_BITS-1:0]          vel_i,
  input  logic        [acr_pkg::DAMP_BITS-1:0] damping_i,
  output logic signed [WORD_BITS:0]            min_o,
  output logic signed [WORD_BITS:0]            max_o,
  output logic signed [WORD_BITS:0]            vel_damp_o
);
  import acr_pkg::*;

  logic signed [WORD_BITS:0]           c_ext;
  logic signed [WORD_BITS:0]           h_ext;
  logic signed [WORD_BITS+DAMP_BITS:0] prod;

  // Box limits, exact in one extra bit.
  assign c_ext = {center_i[WORD_BITS-1], center_i};
  assign h_ext = {2'b00, half_i};
  assign min_o = c_ext - h_ext;
  assign max_o = c_ext + h_ext;

  // Velocity times damping; dropping the fraction bits rounds toward minus infinity.
  assign prod       = vel_i * $signed({1'b0, damping_i});
  assign vel_damp_o = prod[WORD_BITS+DAMP_BITS:DAMP_BITS];

endmodule
`default_nettype wire

// ----- rtl/acr_disp.sv -----
// Per-axis overlap test and minimum displacement against the obstacle.
`default_nettype none
module acr_disp #(
  parameter int WORD_BITS = acr_pkg::WORD_BITS_DEF
) (
  input  logic signed [WORD_BITS:0]   min_i,
  input  logic signed [WORD_BITS:0]   max_i,
  input  logic signed [WORD_BITS:0]   obs_min_i,
  input  logic signed [WORD_BITS:0]   obs_max_i,
  output logic                        overlap_o,
  output logic signed [WORD_BITS+1:0] disp_o,
  output logic        [WORD_BITS+1:0] mag_o
);
  import acr_pkg::*;

  logic signed [WORD_BITS+1:0] d_lo;
  logic signed [WORD_BITS+1:0] d_hi;
  logic        [WORD_BITS+1:0] m_lo;
  logic        [WORD_BITS+1:0] m_hi;

  // Candidate displacements: moving min minus obstacle max, moving max minus obstacle min.
  assign d_lo = {min_i[WORD_BITS], min_i} - {obs_max_i[WORD_BITS], obs_max_i};
  assign d_hi = {max_i[WORD_BITS], max_i} - {obs_min_i[WORD_BITS], obs_min_i};

  // Touching counts as overlap.
  assign overlap_o = (d_lo[WORD_BITS+1] || (d_lo == '0)) && !d_hi[WORD_BITS+1];

  assign m_lo = d_lo[WORD_BITS+1] ? -d_lo : d_lo;
  assign m_hi = d_hi[WORD_BITS+1] ? -d_hi : d_hi;

  // The smaller magnitude wins; on a tie the upper candidate is kept.
  assign disp_o = (m_lo < m_hi) ? d_lo : d_hi;
  assign mag_o  = (m_lo < m_hi) ? m_lo : m_hi;

endmodule
`default_nettype wire

// ----- rtl/acr_resolve.sv -----
// Axis choice and saturated position and velocity response.
`default_nettype none
module acr_resolve #(
  parameter int WORD_BITS = acr_pkg::WORD_BITS_DEF
) (
  input  logic signed [WORD_BITS-1:0] center_i   [acr_pkg::AXES],
  input  logic signed [WORD_BITS-1:0] vel_i      [acr_pkg::AXES],
  input  logic signed [WORD_BITS:0]   vel_damp_i [acr_pkg::AXES],
  input  logic signed [WORD_BITS+1:0] disp_i     [acr_pkg::AXES],
  input  logic        [WORD_BITS+1:0] mag_i      [acr_pkg::AXES],
  input  logic        [acr_pkg::AXES-1:0] overlap_i,
  output acr_pkg::acr_flags_t         flags_o,
  output logic signed [WORD_BITS-1:0] pos_o      [acr_pkg::AXES],
  output logic signed [WORD_BITS-1:0] vel_o      [acr_pkg::AXES]
);
  import acr_pkg::*;

  logic            hit;
  logic [AXES-1:0] pick;
  axis_e           sel_axis;

  // Clamp a wide signed value to the signed word range.
  function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [WORD_BITS+2:0] v);
    logic fits;
    fits = (v[WORD_BITS+2:WORD_BITS-1] == '0) || (v[WORD_BITS+2:WORD_BITS-1] == '1);
    if (fits) begin
      return v[WORD_BITS-1:0];
    end else if (v[WORD_BITS+2]) begin
      return {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_BITS-1){1'b1}}};
    end
  endfunction

  assign hit = &overlap_i;

  // x needs a strictly smaller magnitude than both others, then y; z takes the rest.
  always_comb begin
    pick = '0;
    if ((mag_i[0] < mag_i[1]) && (mag_i[0] < mag_i[2])) begin
      pick[0]  = 1'b1;
      sel_axis = AXIS_X;
    end else if ((mag_i[1] < mag_i[0]) && (mag_i[1] < mag_i[2])) begin
      pick[1]  = 1'b1;
      sel_axis = AXIS_Y;
    end else begin
      pick[2]  = 1'b1;
      sel_axis = AXIS_Z;
    end
  end

  assign flags_o.hit  = hit;
  assign flags_o.axis = hit ? sel_axis : AXIS_X;

  // Per-axis response; without a hit the item passes through unchanged.
  for (genvar i = 0; i < AXES; i++) begin : g_lane
    logic signed [WORD_BITS+2:0] pos_adj;
    logic signed [WORD_BITS+2:0] vel_keep;
    logic signed [WORD_BITS+2:0] vel_flip;

    assign pos_adj  = {{3{center_i[i][WORD_BITS-1]}}, center_i[i]}
                    - {disp_i[i][WORD_BITS+1], disp_i[i]};
    assign vel_keep = {{2{vel_damp_i[i][WORD_BITS]}}, vel_damp_i[i]};
    assign vel_flip = -vel_keep;

    always_comb begin
      if (!hit) begin
        pos_o[i] = center_i[i];
        vel_o[i] = vel_i[i];
      end else if (pick[i]) begin
        pos_o[i] = sat_word(pos_adj);
        vel_o[i] = sat_word(vel_flip);
      end else begin
        pos_o[i] = center_i[i];
        vel_o[i] = sat_word(vel_keep);
      end
    end
  end

endmodule
`default_nettype wire
